// ----- sv/text_mode_character_generator_unit_macros.svh -----
// Assertion macros shared by the character generator RTL.
`ifndef TEXT_MODE_CHARACTER_GENERATOR_UNIT_MACROS_SVH
`define TEXT_MODE_CHARACTER_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TMCG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TMCG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/tmcg_pkg.sv -----
// Package with codes, constants and the result type of the character generator.
package tmcg_pkg;

  localparam int GLYPH_BYTES      = 4096;
  localparam int GLYPH_AW         = 12;
  localparam int DEF_TEXT_COLUMNS = 32;
  localparam int DEF_TEXT_ROWS    = 16;
  localparam int FIFO_DEPTH       = 4;

  localparam logic [1:0] MODE_TEXT   = 2'd0;
  localparam logic [1:0] MODE_FONT   = 2'd1;
  localparam logic [1:0] MODE_PIXELS = 2'd2;

  localparam logic REG_FONT_BANK    = 1'b0;
  localparam logic REG_WHITE_ON_SET = 1'b1;

  typedef struct packed {
    logic [7:0] pixels;
    logic [6:0] scan_line;
    logic [4:0] char_column;
    logic       frame_end;
  } result_t;

endpackage

// ----- sv/text_mode_character_generator_unit.sv -----
// Top level of the 8x8 text-mode character generator with text and font memories.
//
//   channel   direction  handshake                    payload
//   item      in         item_valid / item_ready      mode, address, data
//   result    out        result_valid / result_ready  pixels, scan_line, char_column, frame_end
//   config    in         cfg_write                    cfg_index, cfg_data
//
// One item is taken per cycle while item_ready is high.
// The pixel path runs through the text memory read, the font memory read and the output queue.
// After reset both memories are cleared, one entry a cycle, over max(TEXT_COLUMNS*TEXT_ROWS,
// 4096) entries (4096 by default); no item is taken meanwhile, config writes are.
// A four-entry output queue absorbs result stalls; item_ready drops when it could fill and while clearing.
module text_mode_character_generator_unit import tmcg_pkg::*; #(
  parameter int TEXT_COLUMNS = DEF_TEXT_COLUMNS,
  parameter int TEXT_ROWS    = DEF_TEXT_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  mode,
  input  logic [11:0] address,
  input  logic [7:0]  data,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [7:0]  pixels,
  output logic [6:0]  scan_line,
  output logic [4:0]  char_column,
  output logic        frame_end,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic        cfg_data
);

  localparam int TEXT_CELLS = TEXT_COLUMNS * TEXT_ROWS;
  localparam int SCAN_LINES = 8 * TEXT_ROWS;
  localparam int TAW        = $clog2(TEXT_CELLS);
  localparam int CW         = $clog2(TEXT_COLUMNS);
  localparam int LW         = $clog2(SCAN_LINES);
  localparam int CLEAR_LEN  = (TEXT_CELLS > GLYPH_BYTES) ? TEXT_CELLS : GLYPH_BYTES;
  localparam int CLW        = $clog2(CLEAR_LEN);
  localparam int PW         = $clog2(FIFO_DEPTH);
  localparam int NW         = $clog2(FIFO_DEPTH + 1);
  localparam int QW         = NW + 1;
  localparam logic [4:0] COL_LAST = 5'(TEXT_COLUMNS - 1);

  logic           font_bank;
  logic           white_on_set;
  logic           clearing;
  logic [CLW-1:0] clr_cnt;

  logic [CW-1:0]  col;
  logic [LW-1:0]  line;
  logic [TAW-1:0] row_base;

  logic           accept;
  logic           pix_accept;
  logic           last_col;
  logic           last_line;
  logic [TAW-1:0] cell_idx;

  logic           text_we;
  logic [TAW-1:0] text_wa;
  logic [7:0]     text_wd;
  logic [7:0]     text_rd;
  logic [7:0]     text_mem [TEXT_CELLS];

  logic                glyph_we;
  logic [GLYPH_AW-1:0] glyph_wa;
  logic [7:0]          glyph_wd;
  logic [GLYPH_AW-1:0] glyph_ra;
  logic [7:0]          glyph_rd;
  logic [7:0]          glyph_mem [GLYPH_BYTES];

  logic          v1;
  logic [LW-1:0] line1;
  logic [CW-1:0] col1;
  logic          fe1;
  logic          v2;
  logic [LW-1:0] line2;
  logic [CW-1:0] col2;
  logic          fe2;

  result_t        fifo [FIFO_DEPTH];
  result_t        push_data;
  result_t        head;
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [NW-1:0]  count;
  logic [QW-1:0]  queue_used;
  logic           pop;

  assign queue_used = QW'(count) + QW'(v1) + QW'(v2);
  assign item_ready = !clearing && (queue_used < QW'(FIFO_DEPTH));
  assign accept     = item_valid && item_ready;
  assign pix_accept = accept && (mode == MODE_PIXELS);
  assign last_col   = (col == CW'(TEXT_COLUMNS - 1));
  assign last_line  = (line == LW'(SCAN_LINES - 1));
  assign cell_idx   = row_base + TAW'(col);

  always_ff @(posedge clk) begin
    if (rst) begin
      font_bank    <= 1'b0;
      white_on_set <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FONT_BANK:    font_bank    <= cfg_data;
        REG_WHITE_ON_SET: white_on_set <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == CLW'(CLEAR_LEN - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      line     <= '0;
      row_base <= '0;
    end else if (pix_accept) begin
      if (last_col) begin
        col <= '0;
        if (last_line) begin
          line     <= '0;
          row_base <= '0;
        end else begin
          line <= line + 1'b1;
          if (line[2:0] == 3'd7) begin
            row_base <= row_base + TAW'(TEXT_COLUMNS);
          end
        end
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_comb begin
    if (clearing) begin
      text_we  = (32'(clr_cnt) < TEXT_CELLS);
      text_wa  = TAW'(clr_cnt);
      text_wd  = 8'h00;
      glyph_we = (32'(clr_cnt) < GLYPH_BYTES);
      glyph_wa = GLYPH_AW'(clr_cnt);
      glyph_wd = 8'h00;
    end else begin
      text_we  = accept && (mode == MODE_TEXT) && (32'(address) < TEXT_CELLS);
      text_wa  = TAW'(address);
      text_wd  = data;
      glyph_we = accept && (mode == MODE_FONT);
      glyph_wa = address;
      glyph_wd = data;
    end
  end

  always_ff @(posedge clk) begin
    if (text_we) begin
      text_mem[text_wa] <= text_wd;
    end
    text_rd <= text_mem[cell_idx];
  end

  assign glyph_ra = {font_bank, text_rd, line1[2:0]};

  always_ff @(posedge clk) begin
    if (glyph_we) begin
      glyph_mem[glyph_wa] <= glyph_wd;
    end
    glyph_rd <= glyph_mem[glyph_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= pix_accept;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    line1 <= line;
    col1  <= col;
    fe1   <= last_col && last_line;
    line2 <= line1;
    col2  <= col1;
    fe2   <= fe1;
  end

  assign push_data.pixels      = white_on_set ? glyph_rd : ~glyph_rd;
  assign push_data.scan_line   = 7'(line2);
  assign push_data.char_column = 5'(col2);
  assign push_data.frame_end   = fe2;

  assign pop = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (v2) begin
      fifo[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (v2) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + NW'(v2) - NW'(pop);
    end
  end

  assign head         = fifo[rd_ptr];
  assign result_valid = (count != '0);
  assign pixels       = head.pixels;
  assign scan_line    = head.scan_line;
  assign char_column  = head.char_column;
  assign frame_end    = head.frame_end;

`include "text_mode_character_generator_unit_macros.svh"

  `TMCG_ASSERT_NOW(a_no_item_while_clearing, clearing, !item_ready, "item taken during clear")
  `TMCG_ASSERT_NOW(a_queue_credit, 1'b1, queue_used <= QW'(FIFO_DEPTH), "output queue overcommitted")
  `TMCG_ASSERT_NEXT(a_pixel_enters_pipe, pix_accept, v1, "pixel beat lost at first stage")
  `TMCG_ASSERT_NEXT(a_pipe_advances, v1, v2, "pixel beat lost at second stage")
  `TMCG_ASSERT_NOW(a_frame_end_col, result_valid && frame_end, char_column == COL_LAST, "frame end column")

endmodule

// ----- bench/tb_text_mode_character_generator_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the text-mode character generator.
module tb_text_mode_character_generator_unit import tmcg_pkg::*; ();

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int COLS      = DEF_TEXT_COLUMNS;
  localparam int CELLS     = DEF_TEXT_COLUMNS * DEF_TEXT_ROWS;
  localparam int LAST_LINE = DEF_TEXT_ROWS * 8 - 1;
  localparam int ADDR_MAX  = GLYPH_BYTES - 1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] address;
    logic [7:0]  data;
  } request_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  logic [1:0]  mode;
  logic [11:0] address;
  logic [7:0]  data;
  logic        result_valid;
  logic        result_ready;
  logic [7:0]  pixels;
  logic [6:0]  scan_line;
  logic [4:0]  char_column;
  logic        frame_end;
  logic        cfg_write;
  logic        cfg_index;
  logic        cfg_data;

  logic [7:0] char_codes [CELLS];
  logic [7:0] glyph_rows [GLYPH_BYTES];
  logic [6:0] line_pos;
  logic [4:0] col_pos;
  logic       bank_sel;
  logic       white_sel;
  logic [6:0] plan_line;
  logic [4:0] plan_col;

  request_t requests_to_send [$];
  result_t  groups_due [$];
  request_t next_req;
  result_t  want;
  logic     beat_taken = 1'b0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int beats_queued   = 0;
  int beats_taken    = 0;
  int groups_seen    = 0;
  int frames_seen    = 0;

  text_mode_character_generator_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .mode         (mode),
    .address      (address),
    .data         (data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pixels       (pixels),
    .scan_line    (scan_line),
    .char_column  (char_column),
    .frame_end    (frame_end),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic apply_request(request_t req);
    logic [8:0] cell_idx;
    logic [7:0] row;
    result_t    grp;
    case (req.mode)
      MODE_TEXT: begin
        if (req.address < CELLS) char_codes[req.address[8:0]] = req.data;
      end
      MODE_FONT: begin
        glyph_rows[req.address] = req.data;
      end
      MODE_PIXELS: begin
        cell_idx = {line_pos[6:3], col_pos};
        row = glyph_rows[{bank_sel, char_codes[cell_idx], line_pos[2:0]}];
        grp.pixels      = white_sel ? row : ~row;
        grp.scan_line   = line_pos;
        grp.char_column = col_pos;
        grp.frame_end   = (col_pos == COLS - 1) && (line_pos == LAST_LINE);
        groups_due.push_back(grp);
        if (col_pos == COLS - 1) begin
          col_pos  = '0;
          line_pos = (line_pos == LAST_LINE) ? '0 : line_pos + 7'd1;
        end else begin
          col_pos = col_pos + 5'd1;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic queue_request(logic [1:0] m, logic [11:0] a, logic [7:0] d);
    request_t req;
    req.mode    = m;
    req.address = a;
    req.data    = d;
    requests_to_send.push_back(req);
    beats_queued++;
    if (m == MODE_PIXELS) begin
      if (plan_col == COLS - 1) begin
        plan_col  = '0;
        plan_line = (plan_line == LAST_LINE) ? '0 : plan_line + 7'd1;
      end else begin
        plan_col = plan_col + 5'd1;
      end
    end
  endtask

  task automatic write_reg(logic idx, logic val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_FONT_BANK) begin
      bank_sel = val;
    end else begin
      white_sel = val;
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic fill_random(int count);
    int         made;
    int         pick;
    logic [7:0] code;
    made = 0;
    while (made < count) begin
      pick = int'($urandom_range(99));
      if (pick < 45) begin
        // Load the cell and glyph row that the next group will read, then ask for it.
        code = 8'($urandom_range(255));
        queue_request(MODE_TEXT, {3'b000, plan_line[6:3], plan_col}, code);
        queue_request(MODE_FONT, {bank_sel, code, plan_line[2:0]}, 8'($urandom_range(255)));
        queue_request(MODE_PIXELS, 12'($urandom_range(ADDR_MAX)), 8'($urandom_range(255)));
        made += 3;
      end else if (pick < 75) begin
        queue_request(MODE_PIXELS, 12'($urandom_range(ADDR_MAX)), 8'($urandom_range(255)));
        made++;
      end else if (pick < 85) begin
        queue_request(MODE_FONT, 12'($urandom_range(ADDR_MAX)), 8'($urandom_range(255)));
        made++;
      end else if (pick < 93) begin
        queue_request(MODE_TEXT, 12'($urandom_range(CELLS - 1)), 8'($urandom_range(255)));
        made++;
      end else if (pick < 97) begin
        queue_request(MODE_TEXT, 12'($urandom_range(ADDR_MAX, CELLS)),
                      8'($urandom_range(255)));
        made++;
      end else begin
        queue_request(MODE_UNUSED, 12'($urandom_range(ADDR_MAX)), 8'($urandom_range(255)));
        made++;
      end
    end
  endtask

  task automatic wait_idle();
    while (beats_taken != beats_queued || groups_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_phase(int send_pct, int stall_pct, logic bank, logic white, int count);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    write_reg(REG_FONT_BANK, bank);
    write_reg(REG_WHITE_ON_SET, white);
    fill_random(count);
    wait_idle();
  endtask

  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || beat_taken) begin
      if (requests_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = requests_to_send.pop_front();
        item_valid <= 1'b1;
        mode       <= next_req.mode;
        address    <= next_req.address;
        data       <= next_req.data;
      end else begin
        item_valid <= 1'b0;
      end
    end
    result_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    beat_taken <= !rst && item_valid && item_ready;
    if (!rst && item_valid && item_ready) begin
      beats_taken++;
      apply_request({mode, address, data});
    end
    if (!rst && result_valid && result_ready) begin
      groups_seen++;
      if (groups_due.size() == 0) begin
        errors++;
        $error("result beat with no pixel group pending");
      end else begin
        want = groups_due.pop_front();
        if (pixels !== want.pixels) begin
          errors++;
          $error("pixels: expected %h, got %h", want.pixels, pixels);
        end
        if (scan_line !== want.scan_line) begin
          errors++;
          $error("scan_line: expected %0d, got %0d", want.scan_line, scan_line);
        end
        if (char_column !== want.char_column) begin
          errors++;
          $error("char_column: expected %0d, got %0d", want.char_column, char_column);
        end
        if (frame_end !== want.frame_end) begin
          errors++;
          $error("frame_end: expected %b, got %b", want.frame_end, frame_end);
        end
        if (frame_end === 1'b1) frames_seen++;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    mode         = MODE_TEXT;
    address      = '0;
    data         = '0;
    result_ready = 1'b0;
    cfg_write    = 1'b0;
    cfg_index    = REG_FONT_BANK;
    cfg_data     = 1'b0;
    for (int i = 0; i < CELLS; i++) char_codes[i] = '0;
    for (int i = 0; i < GLYPH_BYTES; i++) glyph_rows[i] = '0;
    line_pos  = '0;
    col_pos   = '0;
    plan_line = '0;
    plan_col  = '0;
    bank_sel  = 1'b0;
    white_sel = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed checks with the reset settings: cleared stores, store extremes,
    // ignored text addresses and the unused mode.
    queue_request(MODE_PIXELS, 12'h000, 8'h00);
    queue_request(MODE_TEXT, 12'd1, 8'hFF);
    queue_request(MODE_FONT, {1'b0, 8'hFF, 3'd0}, 8'hFF);
    queue_request(MODE_PIXELS, 12'hFFF, 8'hFF);
    queue_request(MODE_TEXT, 12'(CELLS - 1), 8'h80);
    queue_request(MODE_TEXT, 12'(CELLS), 8'h3C);
    queue_request(MODE_TEXT, 12'(ADDR_MAX), 8'hFF);
    queue_request(MODE_FONT, 12'(ADDR_MAX), 8'h80);
    queue_request(MODE_FONT, 12'h000, 8'h01);
    queue_request(MODE_UNUSED, 12'(ADDR_MAX), 8'hFF);
    queue_request(MODE_UNUSED, 12'h000, 8'h00);
    queue_request(MODE_PIXELS, 12'h000, 8'h00);
    queue_request(MODE_TEXT, 12'd3, 8'h00);
    queue_request(MODE_PIXELS, 12'h555, 8'hAA);
    queue_request(MODE_FONT, {1'b1, 8'h00, 3'd0}, 8'h7E);
    queue_request(MODE_PIXELS, 12'hAAA, 8'h55);
    wait_idle();

    run_phase(0, 0, 1'b1, 1'b0, 163);
    run_phase(78, 0, 1'b1, 1'b1, 163);
    run_phase(0, 78, 1'b0, 1'b0, 162);
    run_phase(8, 8, 1'b0, 1'b1, 162);

    $display("Run covered %0d item beats and %0d pixel groups, with %0d frame ends seen.",
             beats_taken, groups_seen, frames_seen);
    $display("Both font banks and both polarities were used under four idle patterns.");
    if (errors == 0) begin
      $display("[text_mode_character_generator_unit] OK");
    end else begin
      $display("[text_mode_character_generator_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[text_mode_character_generator_unit] ERROR");
    $finish;
  end

endmodule
